// File: rtl/tkh_pkg.sv
`timescale 1ns / 1ps

package tkh_pkg;

    // default number of heap slots
    localparam int CAPACITY_DEF = 16;

    // command codes carried in cmd
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // register indexes on the apb port (word address)
    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_BOTTOM   = 2'd1;
    localparam logic [1:0] REG_MIDDLE   = 2'd2;

    // widths fixed by the interface
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int CAPR_W  = 5;
    localparam int INDEX_W = 16;
    localparam int VAL_W   = 32;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;

    // one stored heap entry
    typedef struct packed {
        logic [INDEX_W-1:0]      bottom;
        logic [INDEX_W-1:0]      middle;
        logic [INDEX_W-1:0]      top;
        logic signed [VAL_W-1:0] weight;
        logic signed [VAL_W-1:0] z;
    } entry_t;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LAST   = 7'b0000010,
        S_DN_RD  = 7'b0000100,
        S_DN_CMP = 7'b0001000,
        S_UP_RD  = 7'b0010000,
        S_UP_CMP = 7'b0100000,
        S_FIN    = 7'b1000000
    } state_t;

endpackage

// File: rtl/top_k_candidate_min_heap.sv
`timescale 1ns / 1ps

// Bounded min-heap keeping the best candidates by weight (top-k selection).
// Input channel (in_valid/in_ready) takes one command word: push, read slot
// or clear. Output channel (out_valid/out_ready) returns one result word per
// command: accepted flag, entry count, root weight and the read entry.
// Configuration (capacity, bottom and middle index) is for the user to write
// over the apb port only while the block is idle; the block does not enforce it.
// pready is always high. Read, clear, dropped push and the spare code go
// straight to the result state. A push into free room rises from the end,
// level by level; a push replacing the root first moves the last entry to
// the root and sinks it, then the newcomer rises from the end. Each heap
// level takes a read state and a compare/write state, as the single entry
// memory has registered reads. One word is worked on at a time; in_ready is
// high only when idle, from the cycle after the result is loaded.
// Reset empties the heap, sets capacity to zero and both indexes to all ones;
// heap memory contents are not cleared and only slots below the count are
// ever returned. A stalled receiver holds the result register; the block waits
// with its finished word until the result is taken, keeping in_ready low.
module top_k_candidate_min_heap
    import tkh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // apb configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    // input channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                cmd,
    input  logic [INDEX_W-1:0]        top_index,
    input  logic signed [VAL_W-1:0]   cand_weight,
    input  logic signed [VAL_W-1:0]   z_origin,
    input  logic [SLOT_W-1:0]         slot,
    // output channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      accepted,
    output logic [CNT_W-1:0]          count,
    output logic signed [VAL_W-1:0]   lowest_weight,
    output logic                      slot_valid,
    output logic [INDEX_W-1:0]        read_bottom,
    output logic [INDEX_W-1:0]        read_middle,
    output logic [INDEX_W-1:0]        read_top,
    output logic signed [VAL_W-1:0]   read_weight,
    output logic signed [VAL_W-1:0]   read_z
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = CW + 1;
    localparam int KW = (CW > CAPR_W) ? CW : CAPR_W;
    localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int EW = $bits(entry_t);

    // configuration registers
    logic [CAPR_W-1:0]  capacity_reg;
    logic [INDEX_W-1:0] bottom_index_reg;
    logic [INDEX_W-1:0] middle_index_reg;

    // control state
    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      pos_reg, pos_next;
    entry_t             moving_reg, moving_next;
    logic signed [VAL_W-1:0] root_w_reg;
    logic               out_valid_reg, out_valid_next;

    // latched command word
    logic [1:0]         cmd_reg, cmd_next;
    logic [INDEX_W-1:0] top_reg, top_next;
    logic signed [VAL_W-1:0] w_reg, w_next;
    logic signed [VAL_W-1:0] z_reg, z_next;
    logic [IW-1:0]      slot_reg, slot_next;
    logic               acc_reg, acc_next;
    logic               rok_reg, rok_next;

    // result register
    logic               res_acc_reg;
    logic [CNT_W-1:0]   res_count_reg;
    logic signed [VAL_W-1:0] res_lowest_reg;
    logic               res_valid_reg;
    entry_t             res_entry_reg;
    logic               res_load;

    // entry memory
    logic [EW-1:0]      mem [CAPACITY];
    logic               we;
    logic [IW-1:0]      waddr;
    entry_t             wdata;
    logic [IW-1:0]      raddr_a;
    logic [IW-1:0]      raddr_b;
    entry_t             rdata_a;
    entry_t             rdata_b;

    // derived values
    logic               cfg_wr;
    logic [KW-1:0]      cap_x;
    logic [CW-1:0]      cap_eff;
    logic [KW-1:0]      cnt_x;
    logic [SW-1:0]      slot_x;
    logic [IW-1:0]      last_idx;
    logic [NW-1:0]      l_w;
    logic [NW-1:0]      r_w;
    logic               l_ok;
    logic               r_ok;
    logic [IW-1:0]      l_idx;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      up_idx;
    logic               take_r;
    entry_t             pick;
    logic [IW-1:0]      pick_idx;
    entry_t             fresh;
    entry_t             new_entry;
    logic [CW-1:0]      count_m1;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg     <= '0;
            bottom_index_reg <= '1;
            middle_index_reg <= '1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_CAPACITY: capacity_reg     <= pwdata[CAPR_W-1:0];
                REG_BOTTOM:   bottom_index_reg <= pwdata[INDEX_W-1:0];
                REG_MIDDLE:   middle_index_reg <= pwdata[INDEX_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CAPACITY: prdata = DATA_W'(capacity_reg);
            REG_BOTTOM:   prdata = DATA_W'(bottom_index_reg);
            REG_MIDDLE:   prdata = DATA_W'(middle_index_reg);
            default:      prdata = '0;
        endcase
    end

    // capacity saturates at the slot count
    assign cap_x   = KW'(capacity_reg);
    assign cap_eff = (cap_x > KW'(CAPACITY)) ? CW'(CAPACITY) : cap_x[CW-1:0];
    assign cnt_x   = KW'(count_reg);
    assign slot_x  = SW'(slot);
    assign count_m1 = count_reg - CW'(1);
    assign last_idx = count_m1[IW-1:0];

    // children and parent of the current node
    assign l_w        = (NW'(pos_reg) << 1) + NW'(1);
    assign r_w        = l_w + NW'(1);
    assign l_ok       = l_w < NW'(count_reg);
    assign r_ok       = r_w < NW'(count_reg);
    assign l_idx      = l_w[IW-1:0];
    assign r_idx      = r_ok ? r_w[IW-1:0] : '0;
    assign up_idx     = (pos_reg - IW'(1)) >> 1;

    // smaller child, right one on a tie
    assign take_r   = r_ok && !($signed(rdata_a.weight) < $signed(rdata_b.weight));
    assign pick     = take_r ? rdata_b : rdata_a;
    assign pick_idx = take_r ? r_idx : l_idx;

    assign fresh = '{bottom: bottom_index_reg, middle: middle_index_reg,
                     top: top_index, weight: cand_weight, z: z_origin};
    assign new_entry = '{bottom: bottom_index_reg, middle: middle_index_reg,
                         top: top_reg, weight: w_reg, z: z_reg};

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        moving_next    = moving_reg;
        cmd_next       = cmd_reg;
        top_next       = top_reg;
        w_next         = w_reg;
        z_next         = z_reg;
        slot_next      = slot_reg;
        acc_next       = acc_reg;
        rok_next       = rok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_load       = 1'b0;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = moving_reg;
        raddr_a        = '0;
        raddr_b        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    top_next   = top_index;
                    w_next     = cand_weight;
                    z_next     = z_origin;
                    slot_next  = slot_x[IW-1:0];
                    acc_next   = 1'b0;
                    rok_next   = 1'b0;
                    state_next = S_FIN;
                    unique case (cmd)
                        CMD_PUSH:
                        begin
                            if (cap_eff == '0)
                            begin
                                state_next = S_FIN;
                            end
                            else if (count_reg < cap_eff)
                            begin
                                moving_next = fresh;
                                pos_next    = count_reg[IW-1:0];
                                count_next  = count_reg + CW'(1);
                                acc_next    = 1'b1;
                                state_next  = S_UP_RD;
                            end
                            else if ($signed(cand_weight) > $signed(root_w_reg))
                            begin
                                raddr_a    = last_idx;
                                count_next = count_m1;
                                acc_next   = 1'b1;
                                state_next = S_LAST;
                            end
                        end
                        CMD_READ:
                        begin
                            raddr_a  = slot_x[IW-1:0];
                            rok_next = slot_x < SW'(count_reg);
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            // last entry becomes the root and sinks
            S_LAST:
            begin
                moving_next = rdata_a;
                pos_next    = '0;
                state_next  = S_DN_RD;
            end
            S_DN_RD:
            begin
                if (!l_ok)
                begin
                    we          = 1'b1;
                    moving_next = new_entry;
                    pos_next    = count_reg[IW-1:0];
                    count_next  = count_reg + CW'(1);
                    state_next  = S_UP_RD;
                end
                else
                begin
                    raddr_a    = l_idx;
                    raddr_b    = r_idx;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                we = 1'b1;
                if ($signed(pick.weight) < $signed(moving_reg.weight))
                begin
                    wdata      = pick;
                    pos_next   = pick_idx;
                    state_next = S_DN_RD;
                end
                else
                begin
                    moving_next = new_entry;
                    pos_next    = count_reg[IW-1:0];
                    count_next  = count_reg + CW'(1);
                    state_next  = S_UP_RD;
                end
            end
            // new entry rises from the end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    raddr_a    = up_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                we = 1'b1;
                if ($signed(moving_reg.weight) < $signed(rdata_a.weight))
                begin
                    wdata      = rdata_a;
                    pos_next   = up_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            // hand the result word over once the register is free
            S_FIN:
            begin
                raddr_a = slot_reg;
                if (!out_valid_reg || out_ready)
                begin
                    res_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        moving_reg <= moving_next;
        cmd_reg    <= cmd_next;
        top_reg    <= top_next;
        w_reg      <= w_next;
        z_reg      <= z_next;
        slot_reg   <= slot_next;
        acc_reg    <= acc_next;
        rok_reg    <= rok_next;
        if (we && waddr == '0)
        begin
            root_w_reg <= wdata.weight;
        end
    end

    // entry memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_acc_reg    <= acc_reg && (cmd_reg == CMD_PUSH);
            res_count_reg  <= cnt_x[CNT_W-1:0];
            res_lowest_reg <= (count_reg != '0) ? root_w_reg : '0;
            res_valid_reg  <= rok_reg && (cmd_reg == CMD_READ);
            res_entry_reg  <= (rok_reg && (cmd_reg == CMD_READ)) ? rdata_a : '0;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign accepted      = res_acc_reg;
    assign count         = res_count_reg;
    assign lowest_weight = res_lowest_reg;
    assign slot_valid    = res_valid_reg;
    assign read_bottom   = res_entry_reg.bottom;
    assign read_middle   = res_entry_reg.middle;
    assign read_top      = res_entry_reg.top;
    assign read_weight   = res_entry_reg.weight;
    assign read_z        = res_entry_reg.z;

endmodule

// File: dv/tkh_heap_checker.sv
`timescale 1ns / 1ps

module tkh_heap_checker
    import tkh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    input  logic                    pready,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [1:0]              cmd,
    input  logic [INDEX_W-1:0]      top_index,
    input  logic signed [VAL_W-1:0] cand_weight,
    input  logic signed [VAL_W-1:0] z_origin,
    input  logic [SLOT_W-1:0]       slot,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic                    accepted,
    input  logic [CNT_W-1:0]        count,
    input  logic signed [VAL_W-1:0] lowest_weight,
    input  logic                    slot_valid,
    input  logic [INDEX_W-1:0]      read_bottom,
    input  logic [INDEX_W-1:0]      read_middle,
    input  logic [INDEX_W-1:0]      read_top,
    input  logic signed [VAL_W-1:0] read_weight,
    input  logic signed [VAL_W-1:0] read_z,
    output int                      errors,
    output int                      pending
);

    // one result word as the block should return it
    typedef struct packed {
        logic                    accepted;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] lowest;
        logic                    slot_valid;
        logic [INDEX_W-1:0]      bottom;
        logic [INDEX_W-1:0]      middle;
        logic [INDEX_W-1:0]      top;
        logic signed [VAL_W-1:0] weight;
        logic signed [VAL_W-1:0] z;
    } heap_result_t;

    // shadow heap and register copies
    entry_t             heap_mem [CAPACITY_DEF];
    int                 held;
    logic [CAPR_W-1:0]  cap_cfg;
    logic [INDEX_W-1:0] bottom_cfg;
    logic [INDEX_W-1:0] middle_cfg;
    heap_result_t       results_due [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic bit lighter(int a, int b);
        return $signed(heap_mem[a].weight) < $signed(heap_mem[b].weight);
    endfunction

    function automatic void swap_pair(int a, int b);
        entry_t t;
        t           = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    function automatic void rise(int pos);
        int parent;
        while (pos > 0)
        begin
            parent = (pos - 1) / 2;
            if (!lighter(pos, parent))
                return;
            swap_pair(pos, parent);
            pos = parent;
        end
    endfunction

    // lone left child: swap only if smaller; equal children: right one wins
    function automatic void sink(int pos);
        int l;
        int r;
        int pick;
        forever
        begin
            l = 2 * pos + 1;
            r = l + 1;
            if (l >= held)
                return;
            pick = (r >= held || lighter(l, r)) ? l : r;
            if (!lighter(pick, pos))
                return;
            swap_pair(pos, pick);
            pos = pick;
        end
    endfunction

    function automatic void append(logic [INDEX_W-1:0] t_idx, logic signed [VAL_W-1:0] w,
                                   logic signed [VAL_W-1:0] z);
        if (held >= CAPACITY_DEF)
            return;
        heap_mem[held] = '{bottom: bottom_cfg, middle: middle_cfg, top: t_idx,
                           weight: w, z: z};
        held++;
        rise(held - 1);
    endfunction

    // next result word for one command word, updating the shadow heap
    function automatic heap_result_t apply_word(logic [1:0] c, logic [INDEX_W-1:0] t_idx,
                                                logic signed [VAL_W-1:0] w,
                                                logic signed [VAL_W-1:0] z,
                                                logic [SLOT_W-1:0] s);
        heap_result_t res;
        int           lim;
        res = '0;
        lim = (cap_cfg > CAPACITY_DEF) ? CAPACITY_DEF : int'(cap_cfg);
        case (c)
            CMD_PUSH:
            begin
                if (lim != 0 && held < lim)
                begin
                    append(t_idx, w, z);
                    res.accepted = 1'b1;
                end
                else if (lim != 0 && held > 0 && $signed(w) > $signed(heap_mem[0].weight))
                begin
                    // root out, last entry down, newcomer up
                    heap_mem[0] = heap_mem[held - 1];
                    held--;
                    sink(0);
                    append(t_idx, w, z);
                    res.accepted = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (int'(s) < held)
                begin
                    res.slot_valid = 1'b1;
                    res.bottom     = heap_mem[s].bottom;
                    res.middle     = heap_mem[s].middle;
                    res.top        = heap_mem[s].top;
                    res.weight     = heap_mem[s].weight;
                    res.z          = heap_mem[s].z;
                end
            end
            CMD_CLEAR:
                held = 0;
            default:
                ;
        endcase
        res.count  = CNT_W'(held);
        res.lowest = (held > 0) ? heap_mem[0].weight : '0;
        return res;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 200)
            $display("%0t heap check: %s got %h want %h", $time, what, got, want);
    endtask

    task automatic check_result();
        heap_result_t want;
        if (results_due.size() == 0)
        begin
            note_mismatch("result word with nothing due", '0, '0);
            return;
        end
        want = results_due.pop_front();
        if (accepted !== want.accepted)
            note_mismatch("accepted", 64'(accepted), 64'(want.accepted));
        if (count !== want.count)
            note_mismatch("count", 64'(count), 64'(want.count));
        if (lowest_weight !== want.lowest)
            note_mismatch("lowest_weight", 64'(lowest_weight), 64'(want.lowest));
        if (slot_valid !== want.slot_valid)
            note_mismatch("slot_valid", 64'(slot_valid), 64'(want.slot_valid));
        if (read_bottom !== want.bottom)
            note_mismatch("read_bottom", 64'(read_bottom), 64'(want.bottom));
        if (read_middle !== want.middle)
            note_mismatch("read_middle", 64'(read_middle), 64'(want.middle));
        if (read_top !== want.top)
            note_mismatch("read_top", 64'(read_top), 64'(want.top));
        if (read_weight !== want.weight)
            note_mismatch("read_weight", 64'(read_weight), 64'(want.weight));
        if (read_z !== want.z)
            note_mismatch("read_z", 64'(read_z), 64'(want.z));
    endtask

    // watch register writes and both word channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held       = 0;
            cap_cfg    = '0;
            bottom_cfg = '1;
            middle_cfg = '1;
            results_due.delete();
            pending    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_CAPACITY: cap_cfg    = pwdata[CAPR_W-1:0];
                    REG_BOTTOM:   bottom_cfg = pwdata[INDEX_W-1:0];
                    REG_MIDDLE:   middle_cfg = pwdata[INDEX_W-1:0];
                    default:      ;
                endcase
            end
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                results_due.insert(results_due.size(),
                                   apply_word(cmd, top_index, cand_weight, z_origin, slot));
            pending = results_due.size();
        end
    end

endmodule

// File: dv/tb_top_k_candidate_min_heap.sv
`timescale 1ns / 1ps

module tb_top_k_candidate_min_heap;
    import tkh_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         PHASES      = 14;
    localparam int         PHASE_WORDS = 145;
    localparam int         HOLD_CYCLES = 400;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              cmd;
    logic [INDEX_W-1:0]      top_index;
    logic signed [VAL_W-1:0] cand_weight;
    logic signed [VAL_W-1:0] z_origin;
    logic [SLOT_W-1:0]       slot;
    logic                    out_valid;
    logic                    out_ready;
    logic                    accepted;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] lowest_weight;
    logic                    slot_valid;
    logic [INDEX_W-1:0]      read_bottom;
    logic [INDEX_W-1:0]      read_middle;
    logic [INDEX_W-1:0]      read_top;
    logic signed [VAL_W-1:0] read_weight;
    logic signed [VAL_W-1:0] read_z;

    int errors;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    int hold_left = 0;

    top_k_candidate_min_heap DUT (.*);

    tkh_heap_checker u_check (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard stop
    initial
    begin
        #5_000_000;
        $display("tb_top_k_candidate_min_heap: done, errors");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [VAL_W-1:0] pick_weight();
        case ($urandom_range(9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3, 4, 5:
                // few distinct values so ties are common
                return (32'($urandom_range(8)) - 32'd4) << 16;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_z();
        case ($urandom_range(9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return INDEX_W'($urandom_range(65535));
        endcase
    endfunction

    // offer one command word, with a random gap first
    task automatic send_word(logic [1:0] c, logic [INDEX_W-1:0] t_idx,
                             logic [VAL_W-1:0] w, logic [VAL_W-1:0] z,
                             logic [SLOT_W-1:0] s);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        top_index   <= t_idx;
        cand_weight <= w;
        z_origin    <= z;
        slot        <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random(bit no_clear);
        int         pick;
        logic [1:0] c;
        pick = $urandom_range(99);
        if (pick < 58)
            c = CMD_PUSH;
        else if (pick < 92)
            c = CMD_READ;
        else if (pick < 97)
            c = no_clear ? CMD_READ : CMD_CLEAR;
        else
            c = CMD_SPARE;
        send_word(c, pick_index(), pick_weight(), pick_z(), SLOT_W'($urandom_range(15)));
    endtask

    // stop offering and wait until every result word is back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // back-to-back writes of all three registers
    task automatic program_heap(logic [CAPR_W-1:0] cap, logic [INDEX_W-1:0] bot,
                                logic [INDEX_W-1:0] mid);
        logic [1:0]        idx [3];
        logic [DATA_W-1:0] val [3];
        idx[0] = REG_CAPACITY;
        idx[1] = REG_BOTTOM;
        idx[2] = REG_MIDDLE;
        val[0] = DATA_W'(cap);
        val[1] = DATA_W'(bot);
        val[2] = DATA_W'(mid);
        for (int i = 0; i < 3; i++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx[i], 2'b00};
            pwdata  <= val[i];
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [CAPR_W-1:0] phase_cap(int ph);
        case (ph)
            0:       return 5'd16;
            1:       return 5'd1;
            2:       return 5'd2;
            3:       return 5'd31;
            4:       return 5'd5;
            5:       return 5'd16;
            6:       return 5'd3;
            7:       return 5'd0;
            8:       return 5'd8;
            9:       return 5'd20;
            10:      return 5'd16;
            11:      return 5'd4;
            12:      return 5'd1;
            default: return 5'd16;
        endcase
    endfunction

    // stimulus
    initial
    begin
        logic [INDEX_W-1:0] bot;
        logic [INDEX_W-1:0] mid;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        cmd         = CMD_PUSH;
        top_index   = '0;
        cand_weight = '0;
        z_origin    = '0;
        slot        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: capacity zero drops the push, empty read, spare code
        send_word(CMD_PUSH, 16'h0001, 32'h0001_0000, 32'h0, 4'd0);
        send_word(CMD_READ, 16'h0, 32'h0, 32'h0, 4'd0);
        send_word(CMD_SPARE, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
        settle();

        // three slots: fill with extremes, reject equal weights, replace root
        program_heap(5'd3, 16'h0000, 16'hffff);
        send_word(CMD_PUSH, 16'h0000, 32'h7fff_ffff, 32'h8000_0000, 4'd0);
        send_word(CMD_PUSH, 16'hffff, 32'h8000_0000, 32'h7fff_ffff, 4'd0);
        send_word(CMD_PUSH, 16'h1234, 32'h0000_0000, 32'h0000_0000, 4'd0);
        send_word(CMD_PUSH, 16'h5555, 32'h8000_0000, 32'h1111_1111, 4'd0);
        send_word(CMD_PUSH, 16'haaaa, 32'hffff_ffff, 32'hffff_ffff, 4'd0);
        send_word(CMD_PUSH, 16'h0f0f, 32'hffff_ffff, 32'h2222_2222, 4'd0);
        for (int s = 0; s < 4; s++)
            send_word(CMD_READ, 16'h0, 32'h0, 32'h0, SLOT_W'(s));
        send_word(CMD_READ, 16'h0, 32'h0, 32'h0, 4'hf);
        send_word(CMD_CLEAR, 16'h0, 32'h0, 32'h0, 4'd0);
        send_word(CMD_READ, 16'h0, 32'h0, 32'h0, 4'd0);
        send_word(CMD_PUSH, 16'h0001, 32'h0005_0000, 32'h0, 4'd0);
        settle();

        // capacity over the array size, equal weights
        program_heap(5'd31, 16'hffff, 16'h0000);
        for (int i = 0; i < 4; i++)
            send_word(CMD_PUSH, INDEX_W'(i), 32'h0007_0000, 32'h0, 4'd0);
        send_word(CMD_READ, 16'h0, 32'h0, 32'h0, 4'd4);

        // random phases under varying registers and idling
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph % 3)
                0:
                begin
                    bot = '1;
                    mid = '0;
                end
                1:
                begin
                    bot = '0;
                    mid = '1;
                end
                default:
                begin
                    bot = INDEX_W'($urandom_range(65535));
                    mid = INDEX_W'($urandom_range(65535));
                end
            endcase
            program_heap(phase_cap(ph), bot, mid);
            case (ph % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 86;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 86;
                end
                default:
                begin
                    idle_pct  = 10;
                    stall_pct = 10;
                end
            endcase
            // long hold-off on the result side so the input backs up
            if (ph == 9)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
                send_random(ph >= 5 && ph <= 7);
        end

        settle();
        repeat (30) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_top_k_candidate_min_heap: done, clean");
        else
            $display("tb_top_k_candidate_min_heap: done, errors");
        $finish;
    end

endmodule
